@@ hdl/pnc_pkg.sv @@
// ----------------------------------------------------------------------------
// pnc_pkg: shared types and constants for the palette colour mapper
// Command codes, register indexes, word layouts and the luma weighting.
// ----------------------------------------------------------------------------
package pnc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int GSI_DEPTH           = 256;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    localparam logic CFG_COLORS = 1'b0;
    localparam logic CFG_DITHER = 1'b1;

    localparam logic [9:0] DIST_INIT = 10'd1000;

    localparam logic [8:0] LUMA_R = 9'd299;
    localparam logic [9:0] LUMA_G = 10'd587;
    localparam logic [6:0] LUMA_B = 7'd114;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  entry_addr;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
    } pnc_in_t;

    typedef struct packed {
        logic [7:0] color_index;
        logic       found;
    } pnc_out_t;

    // result of the shared distance unit
    typedef struct packed {
        logic [9:0]  cdist;
        logic [17:0] luma;
        logic [7:0]  idx;
    } pnc_dist_t;

    // stored entry: 7..0 blue, 15..8 green, 23..16 red, 31..24 original index
    function automatic logic [7:0] ent_b(input logic [31:0] e);
        return e[7:0];
    endfunction

    function automatic logic [7:0] ent_g(input logic [31:0] e);
        return e[15:8];
    endfunction

    function automatic logic [7:0] ent_r(input logic [31:0] e);
        return e[23:16];
    endfunction

    function automatic logic [7:0] ent_i(input logic [31:0] e);
        return e[31:24];
    endfunction

    // 299 R + 587 G + 114 B, max 255000
    function automatic logic [17:0] luma(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
        logic [17:0] pr;
        logic [17:0] pg;
        logic [17:0] pb;
        pr = 18'(r) * 18'(LUMA_R);
        pg = 18'(g) * 18'(LUMA_G);
        pb = 18'(b) * 18'(LUMA_B);
        return pr + pg + pb;
    endfunction

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/pnc_ram.sv @@
// ----------------------------------------------------------------------------
// pnc_ram: single write, single read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pnc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pnc_dist.sv @@
// ----------------------------------------------------------------------------
// pnc_dist: shared colour distance unit
// Registers L1 distance, luma and original index of one palette word.
// ----------------------------------------------------------------------------
module pnc_dist (
    input  logic                aclk,
    input  logic [31:0]         entry,
    input  logic [7:0]          pix_b,
    input  logic [7:0]          pix_g,
    input  logic [7:0]          pix_r,
    output pnc_pkg::pnc_dist_t  res
);
    import pnc_pkg::*;

    pnc_dist_t res_next;

    always_comb begin
        res_next.cdist = 10'(absdiff(ent_b(entry), pix_b)) + 10'(absdiff(ent_g(entry), pix_g))
                       + 10'(absdiff(ent_r(entry), pix_r));
        res_next.luma  = luma(ent_b(entry), ent_g(entry), ent_r(entry));
        res_next.idx   = ent_i(entry);
    end

    always_ff @(posedge aclk) begin
        res <= res_next;
    end

endmodule

@@ hdl/palette_nearest_colour_map.sv @@
// ----------------------------------------------------------------------------
// palette_nearest_colour_map: green-sorted palette with nearest colour search
// Sequence: a load word writes its entry; a map word reads the green start index,
//   then visits entries outward, each a palette read and a green check, then a
//   distance update unless the early-out ends that walk, paced by the single palette
//   read port and the shared distance unit. Build runs a selection sort (read then
//   compare) per entry with a swap and a green index fill, then fills the index tail.
// Throughput: one word at a time; s_ready is high only between words.
// Reset: aresetn synchronous active low; clears sequencer, output valid and
//   registers (colors_in_use = 256, dither_mode = 0); no clearing pass, the
//   palette and start index hold nothing defined until loaded or built.
// ----------------------------------------------------------------------------
module palette_nearest_colour_map #(
    parameter int PALETTE_ENTRIES = pnc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pnc_pkg::pnc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pnc_pkg::pnc_out_t m_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [8:0]        cfg_wdata
);
    import pnc_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [8:0] PE_W = 9'(PALETTE_ENTRIES);

    // sequencer states
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_B_RDI  = 5'd1;
    localparam logic [4:0] ST_B_GI   = 5'd2;
    localparam logic [4:0] ST_B_SRD  = 5'd3;
    localparam logic [4:0] ST_B_SCMP = 5'd4;
    localparam logic [4:0] ST_B_SWD  = 5'd5;
    localparam logic [4:0] ST_B_SW1  = 5'd6;
    localparam logic [4:0] ST_B_SW2  = 5'd7;
    localparam logic [4:0] ST_B_GCHK = 5'd8;
    localparam logic [4:0] ST_B_FILL = 5'd9;
    localparam logic [4:0] ST_B_NEXT = 5'd10;
    localparam logic [4:0] ST_B_TL0  = 5'd11;
    localparam logic [4:0] ST_B_TAIL = 5'd12;
    localparam logic [4:0] ST_M_RDG  = 5'd13;
    localparam logic [4:0] ST_M_GSI  = 5'd14;
    localparam logic [4:0] ST_M_LOOP = 5'd15;
    localparam logic [4:0] ST_M_URD  = 5'd16;
    localparam logic [4:0] ST_M_UCHK = 5'd17;
    localparam logic [4:0] ST_M_UUPD = 5'd18;
    localparam logic [4:0] ST_M_DSEL = 5'd19;
    localparam logic [4:0] ST_M_DRD  = 5'd20;
    localparam logic [4:0] ST_M_DCHK = 5'd21;
    localparam logic [4:0] ST_M_DUPD = 5'd22;
    localparam logic [4:0] ST_M_DONE = 5'd23;

    logic [4:0] state_reg, state_next;

    // config
    logic [8:0] colors_reg, colors_next;
    logic       dither_reg, dither_next;
    logic [8:0] n_cnt;

    // pixel held for the whole map
    logic [7:0]  pix_b_reg, pix_g_reg, pix_r_reg;
    logic        par_reg;
    logic [17:0] pix_luma_reg, pix_luma_next;

    // build bookkeeping
    logic [8:0]  i_reg, i_next;
    logic signed [9:0] j_reg, j_next;
    logic [8:0]  sp_reg, sp_next;
    logic [7:0]  sv_reg, sv_next;
    logic [31:0] ei_reg, ei_next;
    logic [31:0] spe_reg, spe_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  start_reg, start_next;
    logic [8:0]  k_reg, k_next;

    // search bests
    logic [9:0] best_d_reg, best_d_next;
    logic [7:0] best_reg, best_next;
    logic       best_ok_reg, best_ok_next;
    logic [9:0] dk_d_reg, dk_d_next, br_d_reg, br_d_next;
    logic [7:0] dk_reg, dk_next, br_reg, br_next;
    logic       dk_ok_reg, dk_ok_next, br_ok_reg, br_ok_next;

    // output word
    logic     m_valid_reg, m_valid_next;
    pnc_out_t m_data_reg, m_data_next;

    // memories
    logic          pal_we;
    logic [AW-1:0] pal_waddr, pal_raddr;
    logic [31:0]   pal_wdata, pal_rdata;
    logic          gsi_we;
    logic [7:0]    gsi_waddr, gsi_wdata, gsi_rdata;
    pnc_dist_t     dres;

    logic              accept;
    logic signed [10:0] gdiff;
    logic signed [10:0] bestd_s;
    logic [8:0]        gsi_start;
    logic              dk_sel, br_sel;

    pnc_ram #(.DATA_W(32), .DEPTH(PALETTE_ENTRIES), .ADDR_W(AW)) u_pal (
        .aclk (aclk),
        .we   (pal_we),
        .waddr(pal_waddr),
        .wdata(pal_wdata),
        .raddr(pal_raddr),
        .rdata(pal_rdata)
    );

    pnc_ram #(.DATA_W(8), .DEPTH(GSI_DEPTH), .ADDR_W(8)) u_gsi (
        .aclk (aclk),
        .we   (gsi_we),
        .waddr(gsi_waddr),
        .wdata(gsi_wdata),
        .raddr(pix_g_reg),
        .rdata(gsi_rdata)
    );

    pnc_dist u_dist (
        .aclk (aclk),
        .entry(pal_rdata),
        .pix_b(pix_b_reg),
        .pix_g(pix_g_reg),
        .pix_r(pix_r_reg),
        .res  (dres)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // active count saturated to [2, PALETTE_ENTRIES]
    always_comb begin
        n_cnt = colors_reg;
        if (n_cnt < 9'd2) begin
            n_cnt = 9'd2;
        end
        if (n_cnt > PE_W) begin
            n_cnt = PE_W;
        end
    end

    // config port
    always_comb begin
        colors_next = colors_reg;
        dither_next = dither_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_COLORS: colors_next = cfg_wdata;
                CFG_DITHER: dither_next = cfg_wdata[0];
                default:    colors_next = colors_reg;
            endcase
        end
    end

    // palette read address follows the sequencer
    always_comb begin
        case (state_reg)
            ST_B_SRD, ST_M_DRD: pal_raddr = j_reg[AW-1:0];
            default:            pal_raddr = i_reg[AW-1:0];
        endcase
    end

    // green-distance early-out: up walk uses entry - pixel, down walk pixel - entry
    always_comb begin
        bestd_s = signed'({1'b0, best_d_reg});
        if (state_reg == ST_M_UCHK) begin
            gdiff = signed'({3'b0, ent_g(pal_rdata)}) - signed'({3'b0, pix_g_reg});
        end else begin
            gdiff = signed'({3'b0, pix_g_reg}) - signed'({3'b0, ent_g(pal_rdata)});
        end
    end

    assign gsi_start = (9'(gsi_rdata) > n_cnt) ? n_cnt : 9'(gsi_rdata);

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        sp_next       = sp_reg;
        sv_next       = sv_reg;
        ei_next       = ei_reg;
        spe_next      = spe_reg;
        prev_next     = prev_reg;
        start_next    = start_reg;
        k_next        = k_reg;
        pix_luma_next = pix_luma_reg;
        best_d_next   = best_d_reg;
        best_next     = best_reg;
        best_ok_next  = best_ok_reg;
        dk_d_next     = dk_d_reg;
        br_d_next     = br_d_reg;
        dk_next       = dk_reg;
        br_next       = br_reg;
        dk_ok_next    = dk_ok_reg;
        br_ok_next    = br_ok_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        pal_we        = 1'b0;
        pal_waddr     = i_reg[AW-1:0];
        pal_wdata     = spe_reg;
        gsi_we        = 1'b0;
        gsi_waddr     = prev_reg;
        gsi_wdata     = 8'd0;
        dk_sel        = 1'b0;
        br_sel        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.cmd)
                        CMD_LOAD: begin
                            if ({1'b0, s_data.entry_addr} < PE_W) begin
                                pal_we    = 1'b1;
                                pal_waddr = s_data.entry_addr[AW-1:0];
                                pal_wdata = {s_data.entry_addr, s_data.red,
                                             s_data.green, s_data.blue};
                            end
                        end
                        CMD_BUILD: begin
                            i_next     = 9'd0;
                            prev_next  = 8'd0;
                            start_next = 8'd0;
                            state_next = ST_B_RDI;
                        end
                        CMD_MAP: begin
                            state_next = ST_M_RDG;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            // ---- build: selection sort by green ----
            ST_B_RDI: state_next = ST_B_GI;
            ST_B_GI: begin
                ei_next  = pal_rdata;
                spe_next = pal_rdata;
                sv_next  = ent_g(pal_rdata);
                sp_next  = i_reg;
                j_next   = signed'({1'b0, i_reg}) + 10'sd1;
                if ((i_reg + 9'd1) < n_cnt) begin
                    state_next = ST_B_SRD;
                end else begin
                    state_next = ST_B_SWD;
                end
            end
            ST_B_SRD: state_next = ST_B_SCMP;
            ST_B_SCMP: begin
                if (ent_g(pal_rdata) < sv_reg) begin
                    sp_next  = j_reg[8:0];
                    sv_next  = ent_g(pal_rdata);
                    spe_next = pal_rdata;
                end
                j_next = j_reg + 10'sd1;
                if ((j_reg[8:0] + 9'd1) < n_cnt) begin
                    state_next = ST_B_SRD;
                end else begin
                    state_next = ST_B_SWD;
                end
            end
            ST_B_SWD: begin
                state_next = (sp_reg != i_reg) ? ST_B_SW1 : ST_B_GCHK;
            end
            ST_B_SW1: begin
                pal_we     = 1'b1;
                pal_waddr  = i_reg[AW-1:0];
                pal_wdata  = spe_reg;
                state_next = ST_B_SW2;
            end
            ST_B_SW2: begin
                pal_we     = 1'b1;
                pal_waddr  = sp_reg[AW-1:0];
                pal_wdata  = ei_reg;
                state_next = ST_B_GCHK;
            end
            ST_B_GCHK: begin
                if (sv_reg != prev_reg) begin
                    gsi_we     = 1'b1;
                    gsi_waddr  = prev_reg;
                    gsi_wdata  = 8'(({1'b0, start_reg} + {1'b0, i_reg[7:0]}) >> 1);
                    k_next     = 9'(prev_reg) + 9'd1;
                    state_next = ST_B_FILL;
                end else begin
                    state_next = ST_B_NEXT;
                end
            end
            ST_B_FILL: begin
                if (k_reg < 9'(sv_reg)) begin
                    gsi_we    = 1'b1;
                    gsi_waddr = k_reg[7:0];
                    gsi_wdata = i_reg[7:0];
                    k_next    = k_reg + 9'd1;
                end else begin
                    prev_next  = sv_reg;
                    start_next = i_reg[7:0];
                    state_next = ST_B_NEXT;
                end
            end
            ST_B_NEXT: begin
                i_next     = i_reg + 9'd1;
                state_next = ((i_reg + 9'd1) < n_cnt) ? ST_B_RDI : ST_B_TL0;
            end
            ST_B_TL0: begin
                gsi_we     = 1'b1;
                gsi_waddr  = prev_reg;
                gsi_wdata  = 8'(({1'b0, start_reg} + n_cnt - 9'd1) >> 1);
                k_next     = 9'(prev_reg) + 9'd1;
                state_next = ST_B_TAIL;
            end
            ST_B_TAIL: begin
                if (k_reg < 9'(GSI_DEPTH)) begin
                    gsi_we    = 1'b1;
                    gsi_waddr = k_reg[7:0];
                    gsi_wdata = 8'(n_cnt - 9'd1);
                    k_next    = k_reg + 9'd1;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            // ---- map: outward search from the green start ----
            ST_M_RDG: state_next = ST_M_GSI;
            ST_M_GSI: begin
                i_next        = gsi_start;
                j_next        = signed'({1'b0, gsi_start}) - 10'sd1;
                pix_luma_next = luma(pix_b_reg, pix_g_reg, pix_r_reg);
                best_d_next   = DIST_INIT;
                best_ok_next  = 1'b0;
                dk_d_next     = DIST_INIT;
                br_d_next     = DIST_INIT;
                dk_ok_next    = 1'b0;
                br_ok_next    = 1'b0;
                state_next    = ST_M_LOOP;
            end
            ST_M_LOOP: begin
                if (i_reg < n_cnt) begin
                    state_next = ST_M_URD;
                end else if (!j_reg[9]) begin
                    state_next = ST_M_DSEL;
                end else begin
                    state_next = ST_M_DONE;
                end
            end
            ST_M_URD: state_next = ST_M_UCHK;
            ST_M_UCHK: begin
                if (gdiff >= bestd_s) begin
                    i_next     = n_cnt;
                    state_next = ST_M_DSEL;
                end else begin
                    i_next     = i_reg + 9'd1;
                    state_next = ST_M_UUPD;
                end
            end
            ST_M_DSEL: begin
                state_next = (!j_reg[9]) ? ST_M_DRD : ST_M_LOOP;
            end
            ST_M_DRD: state_next = ST_M_DCHK;
            ST_M_DCHK: begin
                if (gdiff >= bestd_s) begin
                    j_next     = -10'sd1;
                    state_next = ST_M_LOOP;
                end else begin
                    j_next     = j_reg - 10'sd1;
                    state_next = ST_M_DUPD;
                end
            end
            ST_M_UUPD, ST_M_DUPD: begin
                if (!dither_reg) begin
                    if (dres.cdist < best_d_reg) begin
                        best_d_next  = dres.cdist;
                        best_next    = dres.idx;
                        best_ok_next = 1'b1;
                    end
                end else if (dres.cdist == 10'd0) begin
                    dk_d_next  = 10'd0;
                    br_d_next  = 10'd0;
                    dk_next    = dres.idx;
                    br_next    = dres.idx;
                    dk_ok_next = 1'b1;
                    br_ok_next = 1'b1;
                end else if ((dres.luma < pix_luma_reg) && (dres.cdist < dk_d_reg)) begin
                    dk_d_next  = dres.cdist;
                    dk_next    = dres.idx;
                    dk_ok_next = 1'b1;
                end else if ((dres.luma > pix_luma_reg) && (dres.cdist < br_d_reg)) begin
                    br_d_next  = dres.cdist;
                    br_next    = dres.idx;
                    br_ok_next = 1'b1;
                end
                state_next = (state_reg == ST_M_UUPD) ? ST_M_DSEL : ST_M_LOOP;
            end
            ST_M_DONE: begin
                // hold until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (!dither_reg) begin
                        m_data_next.found       = best_ok_reg;
                        m_data_next.color_index = best_ok_reg ? best_reg : 8'd0;
                    end else begin
                        // odd parity wants the darker entry, the other side fills in
                        dk_sel = par_reg ? dk_ok_reg : (!br_ok_reg && dk_ok_reg);
                        br_sel = !dk_sel && br_ok_reg;
                        m_data_next.found       = dk_ok_reg || br_ok_reg;
                        m_data_next.color_index = dk_sel ? dk_reg :
                                                  (br_sel ? br_reg : 8'd0);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            colors_reg  <= 9'd256;
            dither_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            colors_reg  <= colors_next;
            dither_reg  <= dither_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_b_reg <= s_data.blue;
            pix_g_reg <= s_data.green;
            pix_r_reg <= s_data.red;
            par_reg   <= s_data.x_pos[0] ^ s_data.y_pos[0];
        end
        i_reg        <= i_next;
        j_reg        <= j_next;
        sp_reg       <= sp_next;
        sv_reg       <= sv_next;
        ei_reg       <= ei_next;
        spe_reg      <= spe_next;
        prev_reg     <= prev_next;
        start_reg    <= start_next;
        k_reg        <= k_next;
        pix_luma_reg <= pix_luma_next;
        best_d_reg   <= best_d_next;
        best_reg     <= best_next;
        best_ok_reg  <= best_ok_next;
        dk_d_reg     <= dk_d_next;
        br_d_reg     <= br_d_next;
        dk_reg       <= dk_next;
        br_reg       <= br_next;
        dk_ok_reg    <= dk_ok_next;
        br_ok_reg    <= br_ok_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    // up walk never runs past the active count
    a_up_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_URD || state_reg == ST_M_UCHK) |-> (i_reg < n_cnt))
        else $error("up walk index beyond active count");

    // down walk only reads non-negative slots
    a_down_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_DRD || state_reg == ST_M_DCHK) |-> !j_reg[9])
        else $error("down walk index negative");

    // the running minimum never sits behind the scan position
    a_sort_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_SCMP || state_reg == ST_B_SWD) |-> (sp_reg >= i_reg))
        else $error("selection minimum below sort position");

    // a dither pick carries a real distance
    a_dark_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_DONE && dither_reg && dk_ok_reg) |-> (dk_d_reg < DIST_INIT))
        else $error("darker entry flagged without a distance");
`endif

endmodule
